// ===== sv/pprg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pprg_pkg: shared widths, register codes and types
// Fixed-point formats and pipeline payload types of the primary ray generator.
// ----------------------------------------------------------------------------
package pprg_pkg;

    // fraction bits of the pixel coordinate and of the unit direction
    localparam int PIXEL_FRAC_BITS = 4;
    localparam int DIR_FRAC_BITS   = 18;

    // field and register widths
    localparam int PIX_W     = 16;
    localparam int COMP_W    = 21;
    localparam int VEC_W     = 3 * COMP_W;
    localparam int RECIP_W   = 25;
    localparam int CFG_IDX_W = 3;
    localparam int DIR_W     = DIR_FRAC_BITS + 1;

    // screen space has 22 fraction bits
    localparam int SCR_FRAC   = 22;
    localparam int PPROD_W    = PIX_W + RECIP_W;
    localparam int SCRQ_W     = PPROD_W + 1 - (PIXEL_FRAC_BITS + 1);
    localparam int SCR_W      = SCRQ_W + 1;

    // direction accumulation and normalization
    localparam int PROD_W     = COMP_W + SCR_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int MAGF_W     = SUM_W - 1;
    localparam int POS_W      = $clog2(MAGF_W);
    localparam int MAG_W      = 30;
    localparam int SQ_W       = 2 * MAG_W + 2;
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int LEN_W      = MAG_W + 1;
    localparam int QUO_W      = DIR_FRAC_BITS + 1;
    localparam int NUM_W      = MAG_W + DIR_FRAC_BITS + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_VERTICAL   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_W    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_H    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN     = CFG_IDX_W'(5);

    localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(1) << (RECIP_W - 1);

    // normalized magnitudes and signs that ride along the root and divide stages
    typedef struct packed {
        logic                   degen;
        logic [2:0]             neg;
        logic [2:0][MAG_W-1:0]  mag;
    } t_side;

    // sign and zero-length flags after the divider
    typedef struct packed {
        logic       degen;
        logic [2:0] neg;
    } t_sign;

endpackage

// ===== sv/pprg_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pprg_isqrt: pipelined integer square root
// One result bit per stage, floor of the square root of the squared length.
// ----------------------------------------------------------------------------
module pprg_isqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [pprg_pkg::SQ_W-1:0]         i_sq,
    input  pprg_pkg::t_side                   i_side,
    output logic                              o_valid,
    output logic [pprg_pkg::LEN_W-1:0]        o_len,
    output pprg_pkg::t_side                   o_side
);
    import pprg_pkg::*;

    logic              r_v    [0:ROOT_STEPS-1];
    logic [SQ_W-1:0]   r_rem  [0:ROOT_STEPS-1];
    logic [SQ_W-1:0]   r_root [0:ROOT_STEPS-1];
    t_side             r_side [0:ROOT_STEPS-1];

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * g);

        logic            s_v;
        logic [SQ_W-1:0] s_rem;
        logic [SQ_W-1:0] s_root;
        t_side           s_side;
        logic [SQ_W:0]   s_trial;
        logic [SQ_W-1:0] n_rem;
        logic [SQ_W-1:0] n_root;

        // stage input
        if (g == 0) begin : g_first
            assign s_v    = i_valid;
            assign s_rem  = i_sq;
            assign s_root = '0;
            assign s_side = i_side;
        end else begin : g_next
            assign s_v    = r_v[g-1];
            assign s_rem  = r_rem[g-1];
            assign s_root = r_root[g-1];
            assign s_side = r_side[g-1];
        end

        // trial subtract for this result bit
        always_comb begin
            s_trial = {1'b0, s_root} + {1'b0, BIT};
            if ({1'b0, s_rem} >= s_trial) begin
                n_rem  = s_rem - s_trial[SQ_W-1:0];
                n_root = (s_root >> 1) + BIT;
            end else begin
                n_rem  = s_rem;
                n_root = s_root >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_side[g] <= s_side;
            end
        end
    end

    assign o_valid = r_v[ROOT_STEPS-1];
    assign o_len   = r_root[ROOT_STEPS-1][LEN_W-1:0];
    assign o_side  = r_side[ROOT_STEPS-1];

endmodule

// ===== sv/pprg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pprg_div: pipelined rounded division of three magnitudes by the length
// Restoring division, one quotient bit per stage, three lanes side by side.
// ----------------------------------------------------------------------------
module pprg_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic [pprg_pkg::LEN_W-1:0]             i_len,
    input  pprg_pkg::t_side                        i_side,
    output logic                                   o_valid,
    output logic [2:0][pprg_pkg::QUO_W-1:0]        o_quo,
    output pprg_pkg::t_sign                        o_sign
);
    import pprg_pkg::*;

    logic                    r_v    [0:QUO_W];
    logic [2:0][NUM_W-1:0]   r_rem  [0:QUO_W];
    logic [2:0][QUO_W-1:0]   r_quo  [0:QUO_W];
    logic [LEN_W-1:0]        r_len  [0:QUO_W];
    t_sign                   r_sign [0:QUO_W];

    logic [2:0][NUM_W-1:0]   n_num;

    // numerator: magnitude scaled up plus half the length for rounding
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_num[k] = NUM_W'({i_side.mag[k], DIR_FRAC_BITS'(0)}) + NUM_W'(i_len >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]        <= n_num;
            r_quo[0]        <= '0;
            r_len[0]        <= i_len;
            r_sign[0].degen <= i_side.degen;
            r_sign[0].neg   <= i_side.neg;
        end
    end

    for (genvar g = 1; g <= QUO_W; g++) begin : g_step
        localparam int B = QUO_W - g;

        logic [2:0][NUM_W-1:0] n_rem;
        logic [2:0][QUO_W-1:0] n_quo;
        logic [NUM_W:0]        s_dsub;

        // compare and subtract the shifted divisor in each lane
        always_comb begin
            s_dsub = (NUM_W + 1)'(r_len[g-1]) << B;
            n_rem  = r_rem[g-1];
            n_quo  = r_quo[g-1];
            for (int k = 0; k < 3; k++) begin
                if ({1'b0, r_rem[g-1][k]} >= s_dsub) begin
                    n_rem[k]    = r_rem[g-1][k] - s_dsub[NUM_W-1:0];
                    n_quo[k][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= r_v[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_quo[g]  <= n_quo;
                r_len[g]  <= r_len[g-1];
                r_sign[g] <= r_sign[g-1];
            end
        end
    end

    assign o_valid = r_v[QUO_W];
    assign o_quo   = r_quo[QUO_W];
    assign o_sign  = r_sign[QUO_W];

endmodule

// ===== sv/pinhole_primary_ray_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_primary_ray_generator_core: pinhole camera primary ray generator
// Maps a pixel to screen space, forms the view ray and normalizes it.
// ----------------------------------------------------------------------------
// Takes one pixel item per clock while the output does not stall and returns one
// ray item per pixel, in order. Throughput is one item per clock with no stall
// on the output. The pipeline holds nine stages of screen mapping, accumulation,
// leading one search, normalizing shift and squaring, then the square root (one
// result bit per stage, 31 stages) and the rounded divider (one quotient bit per
// stage, 20 stages). The whole pipeline halts while a finished ray waits on
// m_axis_tready. The user must write registers over the cfg port only while no
// item is in flight; the block itself does not enforce this.
module pinhole_primary_ray_generator_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pprg_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pprg_pkg::VEC_W-1:0]             i_cfg_data,
    // pixel items
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [31:0]                            s_axis_tdata,  // pixel_x, pixel_y
    // ray items
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    output logic [119:0]                           m_axis_tdata,
    output logic                                   m_axis_tuser   // degenerate
);
    import pprg_pkg::*;

    localparam logic signed [SCR_W-1:0] SCR_ONE  = SCR_W'(1) << SCR_FRAC;
    localparam logic [PPROD_W:0]        PIX_HALF = (PPROD_W + 1)'(1) << PIXEL_FRAC_BITS;
    localparam logic [DIR_W-1:0]        DIR_LIM  = (DIR_W'(1) << DIR_FRAC_BITS) - DIR_W'(1);
    localparam logic [POS_W-1:0]        TOP_POS  = POS_W'(MAG_W - 1);

    // configuration registers
    logic [VEC_W-1:0]   r_forward;
    logic [VEC_W-1:0]   r_horizontal;
    logic [VEC_W-1:0]   r_vertical;
    logic [RECIP_W-1:0] r_recip_w;
    logic [RECIP_W-1:0] r_recip_h;
    logic [VEC_W-1:0]   r_origin;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forward    <= '0;
            r_horizontal <= '0;
            r_vertical   <= '0;
            r_recip_w    <= RECIP_RESET;
            r_recip_h    <= RECIP_RESET;
            r_origin     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FORWARD:    r_forward    <= i_cfg_data;
                REG_HORIZONTAL: r_horizontal <= i_cfg_data;
                REG_VERTICAL:   r_vertical   <= i_cfg_data;
                REG_RECIP_W:    r_recip_w    <= i_cfg_data[RECIP_W-1:0];
                REG_RECIP_H:    r_recip_h    <= i_cfg_data[RECIP_W-1:0];
                REG_ORIGIN:     r_origin     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance: output register empty or being taken
    logic en;
    logic r_out_valid;
    assign en            = ~r_out_valid | m_axis_tready;
    assign s_axis_tready = en;

    // valid bits of the front stages
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (en) begin
            r1_v <= s_axis_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
    end

    // stage 1: screen coordinates, y flipped
    logic [PPROD_W-1:0]       n_prod_x, n_prod_y;
    logic [PPROD_W:0]         n_rnd_x, n_rnd_y;
    logic [SCRQ_W-1:0]        n_q_x, n_q_y;
    logic signed [SCR_W-1:0]  r1_sx, r1_sy;

    always_comb begin
        n_prod_x = PPROD_W'(s_axis_tdata[PIX_W-1:0]) * PPROD_W'(r_recip_w);
        n_prod_y = PPROD_W'(s_axis_tdata[2*PIX_W-1:PIX_W]) * PPROD_W'(r_recip_h);
        n_rnd_x  = {1'b0, n_prod_x} + PIX_HALF;
        n_rnd_y  = {1'b0, n_prod_y} + PIX_HALF;
        n_q_x    = n_rnd_x[PPROD_W:PIXEL_FRAC_BITS+1];
        n_q_y    = n_rnd_y[PPROD_W:PIXEL_FRAC_BITS+1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sx <= $signed({1'b0, n_q_x}) - SCR_ONE;
            r1_sy <= SCR_ONE - $signed({1'b0, n_q_y});
        end
    end

    // stage 2: span vectors times screen coordinates
    logic signed [2:0][PROD_W-1:0] r2_ph, r2_pv;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r2_ph[k] <= $signed(r_horizontal[COMP_W*k +: COMP_W]) * r1_sx;
                r2_pv[k] <= $signed(r_vertical[COMP_W*k +: COMP_W]) * r1_sy;
            end
        end
    end

    // stage 3: direction components with 40 fraction bits
    logic signed [SUM_W-1:0] n_fwd [3];
    logic signed [SUM_W-1:0] r3_c  [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_fwd[k] = SUM_W'($signed(r_forward[COMP_W*k +: COMP_W])) <<< SCR_FRAC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r3_c[k] <= n_fwd[k] + SUM_W'($signed(r2_ph[k])) + SUM_W'($signed(r2_pv[k]));
            end
        end
    end

    // stage 4: sign and magnitude
    logic [2:0]              r4_neg;
    logic [2:0][MAGF_W-1:0]  r4_mag;
    logic [SUM_W-1:0]        n_abs [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_abs[k] = r3_c[k][SUM_W-1] ? SUM_W'(-r3_c[k]) : SUM_W'(r3_c[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r4_neg[k] <= r3_c[k][SUM_W-1];
                r4_mag[k] <= n_abs[k][MAGF_W-1:0];
            end
        end
    end

    // stage 5: largest magnitude
    logic [MAGF_W-1:0]       n_mx01;
    logic [MAGF_W-1:0]       r5_mx;
    logic [2:0]              r5_neg;
    logic [2:0][MAGF_W-1:0]  r5_mag;

    always_comb begin
        n_mx01 = (r4_mag[0] > r4_mag[1]) ? r4_mag[0] : r4_mag[1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_mx  <= (n_mx01 > r4_mag[2]) ? n_mx01 : r4_mag[2];
            r5_neg <= r4_neg;
            r5_mag <= r4_mag;
        end
    end

    // stage 6: leading one position of the largest magnitude
    logic [POS_W-1:0]        n_pos;
    logic [POS_W-1:0]        r6_pos;
    logic                    r6_degen;
    logic [2:0]              r6_neg;
    logic [2:0][MAGF_W-1:0]  r6_mag;

    always_comb begin
        n_pos = '0;
        for (int i = 0; i < MAGF_W; i++) begin
            if (r5_mx[i]) begin
                n_pos = POS_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_pos   <= n_pos;
            r6_degen <= (r5_mx == '0);
            r6_neg   <= r5_neg;
            r6_mag   <= r5_mag;
        end
    end

    // stage 7: common shift so the largest lands in [2^29, 2^30)
    logic [MAGF_W-1:0] n_shift [3];
    t_side             r7_side;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r6_pos > TOP_POS) begin
                n_shift[k] = r6_mag[k] >> (r6_pos - TOP_POS);
            end else begin
                n_shift[k] = r6_mag[k] << (TOP_POS - r6_pos);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_side.degen <= r6_degen;
            r7_side.neg   <= r6_neg;
            for (int k = 0; k < 3; k++) begin
                r7_side.mag[k] <= n_shift[k][MAG_W-1:0];
            end
        end
    end

    // stage 8: squares
    logic [2:0][2*MAG_W-1:0] r8_sq;
    t_side                   r8_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r8_sq[k] <= (2*MAG_W)'(r7_side.mag[k]) * (2*MAG_W)'(r7_side.mag[k]);
            end
            r8_side <= r7_side;
        end
    end

    // stage 9: squared length
    logic [SQ_W-1:0] r9_sum;
    t_side           r9_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_sum  <= SQ_W'(r8_sq[0]) + SQ_W'(r8_sq[1]) + SQ_W'(r8_sq[2]);
            r9_side <= r8_side;
        end
    end

    // length
    logic             sq_valid;
    logic [LEN_W-1:0] sq_len;
    t_side            sq_side;

    pprg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r9_v),
        .i_sq    (r9_sum),
        .i_side  (r9_side),
        .o_valid (sq_valid),
        .o_len   (sq_len),
        .o_side  (sq_side)
    );

    // unit direction magnitudes
    logic                   dv_valid;
    logic [2:0][QUO_W-1:0]  dv_quo;
    t_sign                  dv_sign;

    pprg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_len   (sq_len),
        .i_side  (sq_side),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_sign  (dv_sign)
    );

    // output register: saturate, apply sign, zero a degenerate ray
    logic [2:0][DIR_W-1:0] n_dir;
    logic [2:0][DIR_W-1:0] r_dir;
    logic                  r_degen;
    logic [DIR_W-1:0]      n_sat [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sat[k] = (DIR_W'(dv_quo[k]) > DIR_LIM) ? DIR_LIM : DIR_W'(dv_quo[k]);
            if (dv_sign.degen) begin
                n_dir[k] = '0;
            end else if (dv_sign.neg[k]) begin
                n_dir[k] = DIR_W'(0) - n_sat[k];
            end else begin
                n_dir[k] = n_sat[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dir   <= n_dir;
            r_degen <= dv_sign.degen;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_dir[2], r_dir[1], r_dir[0], r_origin};
    assign m_axis_tuser  = r_degen;

    // a degenerate ray carries a zero direction
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[119:63] == '0))
        else $error("degenerate ray with nonzero direction");

    // saturation keeps every component strictly inside -1..+1
    a_dir_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[81:63] != 19'h40000 &&
                           m_axis_tdata[100:82] != 19'h40000 &&
                           m_axis_tdata[119:101] != 19'h40000))
        else $error("direction component reached minus one");

    // nothing leaves the pipeline right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("ray item out right after reset");

    // a stalled output holds back new items
    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("item accepted while the pipeline is stalled");

endmodule
